>>> rtl/heading_incremental_pid_mixer_defines.svh
// Assertion macros for the heading PID mixer.
`ifndef HEADING_INCREMENTAL_PID_MIXER_DEFINES_SVH
`define HEADING_INCREMENTAL_PID_MIXER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HIPM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("heading pid mixer: assertion failed");
`define HIPM_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("heading pid mixer: assertion failed");
`else
`define HIPM_ASSERT(label, prop)
`define HIPM_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> rtl/hipm_pkg.sv
// Shared types, constants and register indexes of the heading PID mixer.
`default_nettype none
package hipm_pkg;

	typedef logic signed [16:0] head_t;
	typedef logic signed [17:0] err_t;
	typedef logic signed [18:0] diff1_t;
	typedef logic signed [19:0] diff2_t;
	typedef logic signed [15:0] gain_t;
	typedef logic signed [11:0] base_t;
	typedef logic signed [31:0] acc_t;
	typedef logic signed [12:0] corr_t;
	typedef logic signed [7:0]  pct_t;
	typedef logic signed [12:0] rate_t;
	typedef logic        [1:0]  cfg_idx_t;
	typedef logic        [15:0] cfg_data_t;

	// configuration register indexes
	localparam cfg_idx_t CFG_GAIN_PROP  = 2'd0;
	localparam cfg_idx_t CFG_GAIN_INTEG = 2'd1;
	localparam cfg_idx_t CFG_GAIN_DERIV = 2'd2;
	localparam cfg_idx_t CFG_BASE_RATE  = 2'd3;

	// register reset values
	localparam gain_t GAIN_PROP_RST  = 16'sd256;
	localparam gain_t GAIN_INTEG_RST = 16'sd0;
	localparam gain_t GAIN_DERIV_RST = 16'sd0;
	localparam base_t BASE_RATE_RST  = 12'sd0;

	// increment path widths
	localparam int SUM_W = 37;
	localparam int FRAC_BITS = 8;
	localparam int INC_W = SUM_W - FRAC_BITS;

	// correction clamp and percent scaling: floor(m / 40) == (m * 3277) >> 17 for m <= 4000
	localparam corr_t CORR_LIMIT = 13'sd4000;
	localparam logic [11:0] PCT_RECIP = 12'd3277;
	localparam int PCT_SHIFT = 17;

endpackage
`default_nettype wire

>>> rtl/hipm_mix.sv
// Correction clamp, percent scaling and wheel rate mixing (two pipeline stages).
`default_nettype none
module hipm_mix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc_valid,
	output logic           acc_stall,
	input  hipm_pkg::acc_t acc,
	input  hipm_pkg::base_t base_rate,
	output logic           out_valid,
	input  logic           out_stall,
	output hipm_pkg::corr_t steer_correction,
	output hipm_pkg::pct_t  steer_percent,
	output hipm_pkg::rate_t left_rate,
	output hipm_pkg::rate_t right_rate
);
	import hipm_pkg::*;

	logic        valid_s5, valid_s6;
	logic        rdy_s5, rdy_s6;
	corr_t       corr_s5;
	logic [11:0] mag_s5;
	logic        neg_s5;

	logic signed [24:0] quot;
	corr_t       corr_c;
	logic [23:0] prod;
	logic [6:0]  qmag;
	pct_t        pct_c;
	logic signed [9:0] tri_c;

	// stall chain: a stage loads when it is empty or its contents move on
	assign rdy_s6    = !valid_s6 || !out_stall;
	assign rdy_s5    = !valid_s5 || rdy_s6;
	assign acc_stall = !rdy_s5;
	assign out_valid = valid_s6;

	// divide by 256 toward zero, then clamp
	always_comb begin
		quot = 25'($signed(acc[31:8])) + 25'(acc[31] && (acc[7:0] != 8'd0));
		priority if (quot > 25'(CORR_LIMIT)) begin
			corr_c = CORR_LIMIT;
		end else if (quot < -25'(CORR_LIMIT)) begin
			corr_c = -CORR_LIMIT;
		end else begin
			corr_c = corr_t'(quot);
		end
	end

	// divide magnitude by 40 with a reciprocal, restore sign, mix rates
	always_comb begin
		prod  = 24'(mag_s5) * 24'(PCT_RECIP);
		qmag  = prod[PCT_SHIFT +: 7];
		pct_c = neg_s5 ? -pct_t'({1'b0, qmag}) : pct_t'({1'b0, qmag});
		tri_c = 10'(pct_c) + (10'(pct_c) <<< 1);
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy_s5) valid_s5 <= acc_valid;
			if (rdy_s6) valid_s6 <= valid_s5;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s5 && acc_valid) begin
			corr_s5 <= corr_c;
			mag_s5  <= corr_c[12] ? 12'(-corr_c) : corr_c[11:0];
			neg_s5  <= corr_c[12];
		end
		if (rdy_s6 && valid_s5) begin
			steer_correction <= corr_s5;
			steer_percent    <= pct_c;
			left_rate        <= 13'(base_rate) - 13'(tri_c);
			right_rate       <= 13'(base_rate) + 13'(tri_c);
		end
	end

endmodule
`default_nettype wire

>>> rtl/heading_incremental_pid_mixer.sv
// Heading-hold incremental PID with steering clamp and differential wheel mixing.
//
// Input channel: in_valid / in_stall carry one transaction of measured_heading and
// target_heading (1/256 degree). Output channel: out_valid / out_stall carry
// steer_correction, steer_percent, left_rate and right_rate for each input transaction.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. Index 0..2 write the Q8.8 gains, index 3 writes base_rate (low 12 bits).
// Write configuration only while no transaction is in flight.
// Stages s1 to s4 here and s5, s6 in hipm_mix lie between input acceptance and out_valid.
// Throughput: one transaction per cycle while no stall holds the pipeline; the accumulator
// add and saturate are combinational, and the error history updates at input acceptance.
// Reset: gains return to kp = 1.0, ki = kd = 0, base_rate = 0; accumulator and error
// history clear; the pipeline empties.
// Stall: a held result stays on the outputs; upstream stages keep filling bubbles, and
// in_stall rises only once every stage holds a transaction.
`default_nettype none
`include "heading_incremental_pid_mixer_defines.svh"
module heading_incremental_pid_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  hipm_pkg::cfg_idx_t  cfg_index,
	input  hipm_pkg::cfg_data_t cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  hipm_pkg::head_t    measured_heading,
	input  hipm_pkg::head_t    target_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output hipm_pkg::corr_t    steer_correction,
	output hipm_pkg::pct_t     steer_percent,
	output hipm_pkg::rate_t    left_rate,
	output hipm_pkg::rate_t    right_rate
);
	import hipm_pkg::*;

	gain_t gain_prop_q, gain_integ_q, gain_deriv_q;
	base_t base_rate_q;
	acc_t  acc_q;
	err_t  e1_q, e2_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic mix_stall;
	logic in_accept, ld_s4;

	err_t   err_c;
	diff1_t d1_c;
	diff2_t d2_c;
	err_t   err_s1;
	diff1_t d1_s1;
	diff2_t d2_s1;
	logic signed [34:0] pp_s2;
	logic signed [33:0] pi_s2;
	logic signed [35:0] pd_s2;
	logic signed [SUM_W-1:0] sum_c;
	logic signed [INC_W-1:0] inc_s3;
	logic signed [32:0] acc_sum;
	acc_t  acc_next;

	assign cfg_ready = 1'b1;

	// stall chain over the front stages
	assign rdy_s4    = !valid_s4 || !mix_stall;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign in_stall  = !rdy_s1;
	assign in_accept = in_valid && rdy_s1;
	assign ld_s4     = valid_s3 && rdy_s4;

	// form error and its first and second differences against history
	always_comb begin
		err_c = 18'(target_heading) - 18'(measured_heading);
		d1_c  = 19'(err_c) - 19'(e1_q);
		d2_c  = 20'(err_c) - (20'(e1_q) <<< 1) + 20'(e2_q);
	end

	// sum the products and drop fraction bits (floor)
	assign sum_c = SUM_W'(pp_s2) + SUM_W'(pi_s2) + SUM_W'(pd_s2);

	// saturating accumulate
	always_comb begin
		acc_sum = 33'(acc_q) + 33'(inc_s3);
		unique case (acc_sum[32:31])
			2'b01:   acc_next = {1'b0, {31{1'b1}}};
			2'b10:   acc_next = {1'b1, {31{1'b0}}};
			default: acc_next = acc_sum[31:0];
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= GAIN_PROP_RST;
			gain_integ_q <= GAIN_INTEG_RST;
			gain_deriv_q <= GAIN_DERIV_RST;
			base_rate_q  <= BASE_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN_PROP:  gain_prop_q  <= gain_t'(cfg_data);
				CFG_GAIN_INTEG: gain_integ_q <= gain_t'(cfg_data);
				CFG_GAIN_DERIV: gain_deriv_q <= gain_t'(cfg_data);
				CFG_BASE_RATE:  base_rate_q  <= base_t'(cfg_data[11:0]);
				default: ;
			endcase
		end
	end

	// error history, accumulator and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q     <= '0;
			e2_q     <= '0;
			acc_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_accept) begin
				e2_q <= e1_q;
				e1_q <= err_c;
			end
			if (ld_s4) acc_q <= acc_next;
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (in_accept) begin
			err_s1 <= err_c;
			d1_s1  <= d1_c;
			d2_s1  <= d2_c;
		end
		if (rdy_s2 && valid_s1) begin
			pp_s2 <= 35'(gain_prop_q) * 35'(d1_s1);
			pi_s2 <= 34'(gain_integ_q) * 34'(err_s1);
			pd_s2 <= 36'(gain_deriv_q) * 36'(d2_s1);
		end
		if (rdy_s3 && valid_s2) begin
			inc_s3 <= sum_c[SUM_W-1:FRAC_BITS];
		end
	end

	hipm_mix u_mix (
		.clk              (clk),
		.arst_n           (arst_n),
		.acc_valid        (valid_s4),
		.acc_stall        (mix_stall),
		.acc              (acc_q),
		.base_rate        (base_rate_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.steer_correction (steer_correction),
		.steer_percent    (steer_percent),
		.left_rate        (left_rate),
		.right_rate       (right_rate)
	);

	// correction never leaves the clamp window
	`HIPM_ASSERT(a_corr_range, out_valid |-> (steer_correction <= CORR_LIMIT && steer_correction >= -CORR_LIMIT))
	// wheel rates stay symmetric about the base rate
	`HIPM_ASSERT(a_rate_sym, out_valid |-> ((14'(left_rate) + 14'(right_rate)) == (14'(base_rate_q) + 14'(base_rate_q))))
	// accumulator moves only when stage four loads
	`HIPM_ASSERT_NEXT(a_acc_hold, !ld_s4, $stable(acc_q))
	// older error takes the previous newer error on each accepted transaction
	`HIPM_ASSERT_NEXT(a_hist_order, in_accept, e2_q == $past(e1_q))

endmodule
`default_nettype wire
